[design/dcib_pkg.sv]
// ----------------------------------------------------------------------------
// dcib_pkg: shared types, constants and scale helpers
// Chord tone list types, configuration register map and diatonic scale math
// for the chord interval builder.
// ----------------------------------------------------------------------------
package dcib_pkg;

  localparam int MAX_INTERVALS = 8;
  localparam int LIST_DEPTH    = 7;
  localparam int TONE_W        = 5;
  localparam int COUNT_W       = 3;
  localparam int INDEX_W       = 3;
  localparam int DATA_W        = 4;

  // longest chord actually emitted
  localparam int MAX_TONES = (MAX_INTERVALS < LIST_DEPTH) ? MAX_INTERVALS : LIST_DEPTH;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_SCALE_MODE      = 3'd0;
  localparam logic [INDEX_W-1:0] REG_TONIC_CLASS     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TRIAD_KIND      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_FIRST_EXTENSION = 3'd3;
  localparam logic [INDEX_W-1:0] REG_EXTENSION_MASK  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_DIATONIC_MODE   = 3'd5;

  // triad codes
  localparam logic [2:0] TRI_NONE = 3'd0;
  localparam logic [2:0] TRI_MAJ  = 3'd1;
  localparam logic [2:0] TRI_MIN  = 3'd2;
  localparam logic [2:0] TRI_DIM  = 3'd3;
  localparam logic [2:0] TRI_AUG  = 3'd4;
  localparam logic [2:0] TRI_SUS2 = 3'd5;
  localparam logic [2:0] TRI_SUS4 = 3'd6;
  localparam logic [2:0] TRI_BAD  = 3'd7;

  // first extension codes
  localparam logic [1:0] EXT_NONE  = 2'd0;
  localparam logic [1:0] EXT_SIXTH = 2'd1;
  localparam logic [1:0] EXT_MIN7  = 2'd2;
  localparam logic [1:0] EXT_MAJ7  = 2'd3;

  localparam logic [2:0] MODE_LAST = 3'd6;

  // step pattern per church mode, bit 5 is the first step (1 = whole tone)
  localparam logic [6:0] MODE_STEPS [7] = '{
    7'h37, 7'h2E, 7'h1D, 7'h3B, 7'h36, 7'h2D, 7'h1B
  };

  typedef logic [LIST_DEPTH-1:0][TONE_W-1:0] tone_list_t;
  typedef logic [6:0][3:0] scale_t;

  typedef struct packed {
    logic [2:0] scale_mode;
    logic [3:0] tonic_class;
    logic [2:0] triad_kind;
    logic [1:0] first_extension;
    logic [3:0] extension_mask;
    logic       diatonic_mode;
  } cfg_t;

  typedef struct packed {
    tone_list_t         tones;
    logic [COUNT_W-1:0] count;
  } chord_t;

  function automatic scale_t make_scale(logic [2:0] mode);
    logic [2:0] m;
    logic [6:0] steps;
    logic [3:0] acc;
    scale_t     sc;
    m     = (mode > MODE_LAST) ? 3'd0 : mode;
    steps = MODE_STEPS[m];
    acc   = 4'd0;
    for (int i = 0; i < 7; i++) begin
      sc[i] = acc;
      if (i < 6) begin
        acc = acc + (steps[5-i] ? 4'd2 : 4'd1);
      end
    end
    return sc;
  endfunction

  // semitones from scale degree deg up by off degrees
  function automatic logic [TONE_W-1:0] step_up(scale_t sc, logic [2:0] deg, logic [3:0] off);
    logic [4:0] t;
    logic [2:0] tm;
    logic [5:0] oct;
    logic [5:0] target;
    logic [5:0] diff;
    t = {2'b00, deg} + {1'b0, off};
    if (t >= 5'd14) begin
      tm  = 3'(t - 5'd14);
      oct = 6'd24;
    end else if (t >= 5'd7) begin
      tm  = 3'(t - 5'd7);
      oct = 6'd12;
    end else begin
      tm  = t[2:0];
      oct = 6'd0;
    end
    target = {2'b00, sc[tm]} + oct;
    diff   = target - {2'b00, sc[deg]};
    return diff[TONE_W-1:0];
  endfunction

  // fixed triad third and fifth, element 0 is the third
  function automatic logic [1:0][TONE_W-1:0] triad_tones(logic [2:0] kind);
    logic [1:0][TONE_W-1:0] r;
    case (kind)
      TRI_MAJ:  r = {5'd7, 5'd4};
      TRI_MIN:  r = {5'd7, 5'd3};
      TRI_DIM:  r = {5'd6, 5'd3};
      TRI_AUG:  r = {5'd8, 5'd4};
      TRI_SUS2: r = {5'd7, 5'd2};
      TRI_SUS4: r = {5'd7, 5'd5};
      default:  r = {5'd0, 5'd0};
    endcase
    return r;
  endfunction

endpackage

[design/dcib_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dcib_cfg_regs: configuration register file
// Holds the six chord settings, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module dcib_cfg_regs import dcib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_MODE:      cfg_r.scale_mode      <= cfg_data[2:0];
        REG_TONIC_CLASS:     cfg_r.tonic_class     <= cfg_data[3:0];
        REG_TRIAD_KIND:      cfg_r.triad_kind      <= cfg_data[2:0];
        REG_FIRST_EXTENSION: cfg_r.first_extension <= cfg_data[1:0];
        REG_EXTENSION_MASK:  cfg_r.extension_mask  <= cfg_data[3:0];
        REG_DIATONIC_MODE:   cfg_r.diatonic_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/dcib_chord_calc.sv]
// ----------------------------------------------------------------------------
// dcib_chord_calc: chord tone list builder
// Snaps the key to a scale degree and builds the packed list of chord
// intervals with its length.
// ----------------------------------------------------------------------------
module dcib_chord_calc import dcib_pkg::*; (
  input  logic   [3:0] key,
  input  cfg_t         cfg,
  output chord_t       chord
);

  scale_t                  sc;
  logic [3:0]              tonic;
  logic [3:0]              rel;
  logic [2:0]              deg;
  logic [1:0][TONE_W-1:0]  tri_pair;
  logic [LIST_DEPTH-1:0]   en;
  tone_list_t              cand;
  tone_list_t              list;
  logic [COUNT_W-1:0]      pos;
  logic [COUNT_W-1:0]      count;
  logic                    tri_fixed;
  logic                    tri_diatonic;

  always_comb begin
    sc    = make_scale(cfg.scale_mode);
    tonic = (cfg.tonic_class >= 4'd12) ? cfg.tonic_class - 4'd12 : cfg.tonic_class;
    rel   = (key >= tonic) ? key - tonic : 4'(5'(key) + 5'd12 - 5'(tonic));

    // nearest degree at or below: highest scale step not above rel
    deg = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (sc[i] <= rel) begin
        deg = deg + 3'd1;
      end
    end

    tri_pair     = triad_tones(cfg.triad_kind);
    tri_fixed    = (cfg.triad_kind != TRI_NONE) && (cfg.triad_kind != TRI_BAD);
    tri_diatonic = (cfg.triad_kind == TRI_NONE) && cfg.diatonic_mode;

    en[0]   = 1'b1;
    cand[0] = '0;
    en[1]   = tri_fixed || tri_diatonic;
    en[2]   = en[1];
    cand[1] = tri_fixed ? tri_pair[0] : step_up(sc, deg, 4'd2);
    cand[2] = tri_fixed ? tri_pair[1] : step_up(sc, deg, 4'd4);

    case (cfg.first_extension)
      EXT_SIXTH: begin
        en[3]   = 1'b1;
        cand[3] = 5'd9;
      end
      EXT_MIN7: begin
        en[3]   = 1'b1;
        cand[3] = 5'd10;
      end
      EXT_MAJ7: begin
        en[3]   = 1'b1;
        cand[3] = 5'd11;
      end
      default: begin
        en[3]   = cfg.extension_mask[0];
        cand[3] = step_up(sc, deg, 4'd6);
      end
    endcase

    en[4]   = cfg.extension_mask[1];
    cand[4] = step_up(sc, deg, 4'd8);
    en[5]   = cfg.extension_mask[2];
    cand[5] = step_up(sc, deg, 4'd10);
    en[6]   = cfg.extension_mask[3];
    cand[6] = step_up(sc, deg, 4'd12);

    // pack enabled tones to the front
    list = '0;
    pos  = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (en[k]) begin
        list[pos] = cand[k];
        pos       = pos + 3'd1;
      end
    end

    count = (pos > COUNT_W'(MAX_TONES)) ? COUNT_W'(MAX_TONES) : pos;
    if (key >= 4'd12) begin
      count = '0;
    end

    chord.tones = list;
    chord.count = count;
  end

endmodule

[design/dcib_serializer.sv]
// ----------------------------------------------------------------------------
// dcib_serializer: chord buffer and tone shifter
// Holds one finished chord while the previous one is shifted out, one tone
// per cycle, with the last tone flagged.
// ----------------------------------------------------------------------------
module dcib_serializer import dcib_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              chord_valid,
  input  chord_t            chord,
  output logic              chord_free,
  output logic              strobe,
  output logic [TONE_W-1:0] interval,
  output logic              last_tone
);

  // chord buffer
  logic               buf_v;
  tone_list_t         buf_tones;
  logic [COUNT_W-1:0] buf_count;

  // shifter
  logic               emit_v;
  tone_list_t         emit_tones;
  logic [COUNT_W-1:0] emit_rem;

  logic emit_last;
  logic buf_take;
  logic buf_load;

  assign emit_last  = emit_v && (emit_rem == COUNT_W'(1));
  assign buf_take   = buf_v && (!emit_v || emit_last);
  assign chord_free = !buf_v || buf_take;
  assign buf_load   = chord_valid && (chord.count != '0) && chord_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_v <= 1'b0;
    end else if (buf_load) begin
      buf_v <= 1'b1;
    end else if (buf_take) begin
      buf_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      buf_tones <= chord.tones;
      buf_count <= chord.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_v <= 1'b0;
    end else if (buf_take) begin
      emit_v <= 1'b1;
    end else if (emit_last) begin
      emit_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take) begin
      emit_tones <= buf_tones;
      emit_rem   <= buf_count;
    end else if (emit_v) begin
      emit_tones <= {TONE_W'(0), emit_tones[LIST_DEPTH-1:1]};
      emit_rem   <= emit_rem - COUNT_W'(1);
    end
  end

  assign strobe    = emit_v;
  assign interval  = emit_tones[0];
  assign last_tone = emit_last;

endmodule

[design/diatonic_chord_interval_builder_top.sv]
// ----------------------------------------------------------------------------
// diatonic_chord_interval_builder_top: chord interval builder
// Takes a pressed key's pitch class and emits the semitone intervals of the
// chord built on it, one tone per strobe.
// ----------------------------------------------------------------------------
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------
//   key in   | start / busy     | key_class
//   tones    | strobe           | interval, last_tone
//   config   | cfg_we           | cfg_index, cfg_data
//
// a key is registered and its chord is built combinationally into a chord
// buffer, then moved to the shifter and shifted out one tone per cycle; the
// first tone appears once the key register, chord buffer and shifter are loaded.
// keys can enter while a chord shifts out; a key of 12 or more gives no tones.
// busy rises only when the input register and chord buffer are both full.
// rst is synchronous and clears all control state and config registers.
// ----------------------------------------------------------------------------
module diatonic_chord_interval_builder_top import dcib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         key_class,
  output logic               strobe,
  output logic [TONE_W-1:0]  interval,
  output logic               last_tone,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  chord_t     chord;
  logic       key_v;
  logic [3:0] key_r;
  logic       chord_free;
  logic       accept;

  assign busy   = key_v && !chord_free;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_v <= 1'b0;
    end else if (accept) begin
      key_v <= 1'b1;
    end else if (chord_free) begin
      key_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key_class;
    end
  end

  dcib_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcib_chord_calc u_calc (
    .key   (key_r),
    .cfg   (cfg),
    .chord (chord)
  );

  dcib_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .chord_valid (key_v),
    .chord       (chord),
    .chord_free  (chord_free),
    .strobe      (strobe),
    .interval    (interval),
    .last_tone   (last_tone)
  );

endmodule
